>>> src/rsfl_pkg.sv
// shared types and constants for the record slot free list
package rsfl_pkg;

    localparam int SLOT_COUNT = 1024;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int COUNT_W    = $clog2(SLOT_COUNT + 1);
    localparam int KEY_W      = 32;
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 2;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 2'd0,
        FN_REMOVE = 2'd1,
        FN_READ   = 2'd2,
        FN_UPDATE = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    // one slot of the record table
    typedef struct packed {
        logic              deleted;
        logic [SLOT_W-1:0] link;
        logic [KEY_W-1:0]  key;
    } t_entry;

endpackage

>>> src/record_slot_free_list_top.sv
// record slot table with logical deletion and a lifo free list
//
//  channel  | valid   | ready   | payload
//  ---------+---------+---------+-------------------------------------
//  request  | i_valid | o_ready | i_func, i_slot, i_new_key
//  response | o_valid | i_ready | o_status, o_slot_used, o_key_out
//
// an item goes through a slot memory read, then decide, write back and load the
// response register. an insert that pops the free stack also goes through a link state
// when the popped slot links to another slot, not itself, below the used count, as the
// deleted flag of that slot needs a second read of the slot memory.
// reset is synchronous active low and clears the free stack and used count; the
// slot memory is not cleared. a stalled response holds the block in its decide cycle.
module record_slot_free_list_top
    import rsfl_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [SLOT_W-1:0]   i_slot,
    input  logic signed [KEY_W-1:0] i_new_key,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [SLOT_W-1:0]   o_slot_used,
    output logic signed [KEY_W-1:0] o_key_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_LINK
    } t_state;

    t_entry r_mem [SLOT_COUNT];
    t_entry r_rd_data;

    t_state              r_state, n_state;
    logic                r_out_valid, n_out_valid;
    t_status             r_status, n_status;
    logic [SLOT_W-1:0]   r_slot_used, n_slot_used;
    logic [KEY_W-1:0]    r_key_out, n_key_out;
    logic [SLOT_W-1:0]   r_free_top, n_free_top;
    logic                r_free_nonempty, n_free_nonempty;
    logic [COUNT_W-1:0]  r_used_count, n_used_count;
    t_func               r_func, n_func;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [KEY_W-1:0]    r_key, n_key;

    logic                accept;
    logic                out_free;
    logic                live;
    logic                rd_en;
    logic [SLOT_W-1:0]   rd_addr;
    logic                wr_en;
    logic [SLOT_W-1:0]   wr_addr;
    t_entry              wr_data;

    assign o_ready     = (r_state == S_IDLE);
    assign accept      = i_valid && o_ready;
    assign out_free    = !r_out_valid || i_ready;
    assign live        = ({1'b0, r_slot} < r_used_count) && !r_rd_data.deleted;
    assign o_valid     = r_out_valid;
    assign o_status    = r_status;
    assign o_slot_used = r_slot_used;
    assign o_key_out   = r_key_out;

    always_comb begin
        n_state         = r_state;
        n_out_valid     = r_out_valid && !i_ready;
        n_status        = r_status;
        n_slot_used     = r_slot_used;
        n_key_out       = r_key_out;
        n_free_top      = r_free_top;
        n_free_nonempty = r_free_nonempty;
        n_used_count    = r_used_count;
        n_func          = r_func;
        n_slot          = r_slot;
        n_key           = r_key;
        rd_en           = 1'b0;
        rd_addr         = r_rd_data.link;
        wr_en           = 1'b0;
        wr_addr         = r_slot;
        wr_data         = r_rd_data;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    rd_en   = 1'b1;
                    rd_addr = (t_func'(i_func) == FN_INSERT) ? r_free_top : i_slot;
                    n_func  = t_func'(i_func);
                    n_slot  = i_slot;
                    n_key   = i_new_key;
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    n_status    = ST_OK;
                    n_slot_used = r_slot;
                    n_key_out   = r_key;
                    if (r_func == FN_INSERT) begin
                        if (r_free_nonempty) begin
                            // pop: reuse top slot, link becomes new top
                            wr_en       = 1'b1;
                            wr_addr     = r_free_top;
                            wr_data     = '{deleted: 1'b0, link: r_rd_data.link, key: r_key};
                            n_slot_used = r_free_top;
                            n_free_top  = r_rd_data.link;
                            if (({1'b0, r_rd_data.link} < r_used_count) &&
                                (r_rd_data.link != r_free_top)) begin
                                rd_en   = 1'b1;
                                rd_addr = r_rd_data.link;
                                n_state = S_LINK;
                            end else begin
                                n_free_nonempty = 1'b0;
                            end
                        end else if (r_used_count < COUNT_W'(SLOT_COUNT)) begin
                            wr_en        = 1'b1;
                            wr_addr      = r_used_count[SLOT_W-1:0];
                            wr_data      = '{deleted: 1'b0, link: '0, key: r_key};
                            n_slot_used  = r_used_count[SLOT_W-1:0];
                            n_used_count = r_used_count + COUNT_W'(1);
                        end else begin
                            n_status    = ST_FULL;
                            n_slot_used = '0;
                            n_key_out   = '0;
                        end
                    end else if (!live) begin
                        n_status  = ST_NOT_FOUND;
                        n_key_out = '0;
                    end else begin
                        case (r_func)
                            FN_REMOVE: begin
                                wr_en           = 1'b1;
                                wr_data         = '{deleted: 1'b1, link: r_free_top,
                                                    key: r_rd_data.key};
                                n_key_out       = r_rd_data.key;
                                n_free_top      = r_slot;
                                n_free_nonempty = 1'b1;
                            end
                            FN_UPDATE: begin
                                wr_en   = 1'b1;
                                wr_data = '{deleted: 1'b0, link: r_rd_data.link, key: r_key};
                            end
                            default: begin
                                n_key_out = r_rd_data.key;
                            end
                        endcase
                    end
                end
            end
            S_LINK: begin
                // stack stays nonempty only if the new top is still a deleted slot
                n_free_nonempty = r_rd_data.deleted;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_out_valid     <= 1'b0;
            r_free_top      <= '0;
            r_free_nonempty <= 1'b0;
            r_used_count    <= '0;
        end else begin
            r_state         <= n_state;
            r_out_valid     <= n_out_valid;
            r_free_top      <= n_free_top;
            r_free_nonempty <= n_free_nonempty;
            r_used_count    <= n_used_count;
        end
        r_status    <= n_status;
        r_slot_used <= n_slot_used;
        r_key_out   <= n_key_out;
        r_func      <= n_func;
        r_slot      <= n_slot;
        r_key       <= n_key;
    end

    a_link_after_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LINK) |-> $past(r_state == S_LOOK))
        else $error("link check entered without a decide cycle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used_count <= COUNT_W'(SLOT_COUNT))
        else $error("used count beyond slot count");

    a_write_in_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == S_LOOK) && out_free)
        else $error("slot write outside the decide cycle");

    a_remove_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_LOOK) && out_free && (r_func == FN_REMOVE) && live)
        |=> r_free_nonempty && (r_free_top == $past(r_slot)))
        else $error("removed slot not on top of free stack");

endmodule

>>> tb/record_slot_free_list_top_tb.sv
// self-checking testbench for the record slot free list top level
module record_slot_free_list_top_tb;
    import rsfl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1680;
    localparam int SETTLE_CYCLES = 20;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [KEY_W-1:0]    key;
    } t_slot_resp;

    // mirror of the slot table and its free stack, plus the responses it predicts
    class t_slot_scoreboard;
        logic [KEY_W-1:0]  key_of [SLOT_COUNT];
        logic              is_deleted [SLOT_COUNT];
        logic [SLOT_W-1:0] link_of [SLOT_COUNT];
        logic [SLOT_W-1:0] stack_top = '0;
        logic              stack_nonempty = 1'b0;
        logic [COUNT_W-1:0] used_count = '0;
        t_slot_resp        pending_resp[$];
        int                mismatch_count = 0;

        function void note_request(t_func f, logic [SLOT_W-1:0] s, logic [KEY_W-1:0] k);
            t_slot_resp r;
            logic [SLOT_W-1:0] grab;
            logic [SLOT_W-1:0] nxt;
            r.status = ST_OK;
            r.slot   = s;
            r.key    = '0;
            if (f == FN_INSERT) begin
                if (stack_nonempty) begin
                    grab = stack_top;
                    nxt = link_of[grab];
                    key_of[grab] = k;
                    is_deleted[grab] = 1'b0;
                    stack_top = nxt;
                    // deleted slots are exactly the ones still on the stack
                    stack_nonempty = (nxt < used_count) && is_deleted[nxt];
                    r.slot = grab;
                    r.key  = k;
                end else if (used_count < SLOT_COUNT) begin
                    grab = used_count[SLOT_W-1:0];
                    key_of[grab] = k;
                    is_deleted[grab] = 1'b0;
                    link_of[grab] = '0;
                    used_count++;
                    r.slot = grab;
                    r.key  = k;
                end else begin
                    r.status = ST_FULL;
                    r.slot   = '0;
                end
            end else if (!(s < used_count) || is_deleted[s]) begin
                r.status = ST_NOT_FOUND;
            end else begin
                case (f)
                    FN_REMOVE: begin
                        r.key = key_of[s];
                        is_deleted[s] = 1'b1;
                        link_of[s] = stack_top;
                        stack_top = s;
                        stack_nonempty = 1'b1;
                    end
                    FN_READ: begin
                        r.key = key_of[s];
                    end
                    default: begin
                        key_of[s] = k;
                        r.key = k;
                    end
                endcase
            end
            pending_resp.push_back(r);
        endfunction

        function void check_response(logic [STATUS_W-1:0] st, logic [SLOT_W-1:0] s,
                                     logic [KEY_W-1:0] k);
            t_slot_resp e;
            if (pending_resp.size() == 0) begin
                if (mismatch_count < 10)
                    $display("error: response beat with nothing pending: %s %0d %0d %h",
                             "status slot key", st, s, k);
                mismatch_count++;
            end else begin
                e = pending_resp.pop_front();
                if (st !== e.status || s !== e.slot || k !== e.key) begin
                    if (mismatch_count < 10)
                        $display({"error: expected status %0d slot %0d key %h, ",
                                  "got status %0d slot %0d key %h"},
                                 e.status, e.slot, e.key, st, s, k);
                    mismatch_count++;
                end
            end
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    logic [FUNC_W-1:0]       i_func;
    logic [SLOT_W-1:0]       i_slot;
    logic signed [KEY_W-1:0] i_new_key;
    logic                    o_valid;
    logic                    i_ready;
    logic [STATUS_W-1:0]     o_status;
    logic [SLOT_W-1:0]       o_slot_used;
    logic signed [KEY_W-1:0] o_key_out;

    t_slot_scoreboard model;
    bit req_steady;
    bit resp_steady;

    record_slot_free_list_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_func      (i_func),
        .i_slot      (i_slot),
        .i_new_key   (i_new_key),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_status    (o_status),
        .o_slot_used (o_slot_used),
        .o_key_out   (o_key_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // idle gap per beat, with occasional runs of back-to-back beats
    function automatic int next_gap(inout bit steady);
        if ($urandom_range(0, 39) == 0)
            steady = ~steady;
        return steady ? 0 : $urandom_range(0, 8);
    endfunction

    task automatic send_request(input t_func f, input logic [SLOT_W-1:0] s,
                                input logic [KEY_W-1:0] k);
        int gap;
        gap = next_gap(req_steady);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_func    <= f;
        i_slot    <= s;
        i_new_key <= k;
        do @(posedge i_clk); while (!o_ready);
        model.note_request(f, s, k);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 15) == 0) begin
            case ($urandom_range(0, 3))
                0:       return 32'h0000_0000;
                1:       return 32'hFFFF_FFFF;
                2:       return 32'h7FFF_FFFF;
                default: return 32'h8000_0000;
            endcase
        end
        return $urandom;
    endfunction

    // mostly slots that were ever appended, so removes and reads hit real entries
    function automatic logic [SLOT_W-1:0] pick_slot();
        if (model.used_count != 0 && $urandom_range(0, 99) < 75)
            return SLOT_W'($urandom_range(0, model.used_count - 1));
        return SLOT_W'($urandom_range(0, SLOT_COUNT - 1));
    endfunction

    initial begin
        #5ms;
        $display("FAIL record_slot_free_list_top");
        $finish;
    end

    // response side: random backpressure, check every accepted beat
    initial begin
        int gap;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = next_gap(resp_steady);
            @(negedge i_clk);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            model.check_response(o_status, o_slot_used, o_key_out);
        end
    end

    initial begin
        t_func f;
        int    pick;
        model = new;
        req_steady = 1'b0;
        resp_steady = 1'b0;
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_ready   = 1'b0;
        i_func    = FN_INSERT;
        i_slot    = '0;
        i_new_key = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty table: every lookup misses
        send_request(FN_READ,   10'd0,   32'h0);
        send_request(FN_REMOVE, 10'd1023, 32'h0);
        send_request(FN_UPDATE, 10'd5,   32'h1111_2222);
        send_request(FN_INSERT, 10'd0,   32'h7FFF_FFFF);
        send_request(FN_INSERT, 10'd1023, 32'h8000_0000);
        send_request(FN_INSERT, 10'd512, 32'hFFFF_FFFF);
        send_request(FN_INSERT, 10'd0,   32'h0000_0000);
        send_request(FN_READ,   10'd0,   32'h0);
        send_request(FN_READ,   10'd1,   32'h0);
        send_request(FN_UPDATE, 10'd2,   32'h1234_5678);
        send_request(FN_READ,   10'd2,   32'h0);
        // just past the appended range
        send_request(FN_READ,   10'd4,   32'h0);
        send_request(FN_REMOVE, 10'd1,   32'h0);
        // deleted slot misses for every lookup
        send_request(FN_READ,   10'd1,   32'h0);
        send_request(FN_UPDATE, 10'd1,   32'h5555_AAAA);
        send_request(FN_REMOVE, 10'd1,   32'h0);
        send_request(FN_REMOVE, 10'd3,   32'h0);
        // pop keeps the stack alive through the link, then drains it
        send_request(FN_INSERT, 10'd0,   32'hDEAD_BEEF);
        send_request(FN_INSERT, 10'd0,   32'hCAFE_F00D);
        send_request(FN_INSERT, 10'd0,   32'h0BAD_F00D);
        send_request(FN_REMOVE, 10'd0,   32'h0);
        send_request(FN_REMOVE, 10'd4,   32'h0);
        send_request(FN_READ,   10'd4,   32'h0);
        send_request(FN_INSERT, 10'd0,   32'hA5A5_5A5A);
        send_request(FN_INSERT, 10'd0,   32'h5A5A_A5A5);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (model.used_count < SLOT_COUNT) begin
                // fill toward a full table with some lookups and frees mixed in
                if (pick < 90)      f = FN_INSERT;
                else if (pick < 94) f = FN_REMOVE;
                else if (pick < 97) f = FN_READ;
                else                f = FN_UPDATE;
            end else begin
                // full table: churn the free stack and hit the full response
                if (pick < 40)      f = FN_INSERT;
                else if (pick < 70) f = FN_REMOVE;
                else if (pick < 85) f = FN_READ;
                else                f = FN_UPDATE;
            end
            send_request(f, pick_slot(), pick_key());
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (model.pending_resp.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (model.mismatch_count == 0 && model.pending_resp.size() == 0)
            $display("PASS record_slot_free_list_top");
        else
            $display("FAIL record_slot_free_list_top");
        $finish;
    end

endmodule

>>> filelist.f
src/rsfl_pkg.sv
src/record_slot_free_list_top.sv
tb/record_slot_free_list_top_tb.sv
